>>> rtl/haversine_distance_top_assert.svh
// ----------------------------------------------------------------------------
// Haversine distance assertion macros
// Concurrent checks for the haversine distance pipeline; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_TOP_ASSERT_SVH
`define HAVERSINE_DISTANCE_TOP_ASSERT_SVH
`ifndef SYNTH
`define HVD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("haversine distance check failed");
`define HVD_ASSERT_DLY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error("haversine distance check failed");
`else
`define HVD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HVD_ASSERT_DLY(label, clk, rst_n, ante, n, cons)
`endif
`endif

>>> rtl/hvd_pkg.sv
// ----------------------------------------------------------------------------
// Haversine distance package
// Fixed constants and elaboration-time table functions for the CORDIC rows.
// ----------------------------------------------------------------------------
package hvd_pkg;

    typedef logic [63:0] t_u64;

    localparam t_u64                PI_Q60       = 64'h3243F6A8885A308D;
    localparam t_u64                DEG_DIVISOR  = 64'd3515625;
    localparam int                  TABLE_LEN    = 32;
    localparam logic signed [33:0]  LON_TURN     = 34'sd3600000000;
    localparam logic signed [33:0]  LON_HALF     = 34'sd1800000000;
    localparam logic [30:0]         DIST_MAX     = 31'h7FFFFFFF;
    localparam logic [22:0]         RADIUS_RESET = 23'd6378137;
    localparam logic [6:0]          CM_PER_M     = 7'd100;
    localparam int                  X100_W       = 30;

    // restoring long division, one quotient bit per pass
    function automatic t_u64 f_udiv(input t_u64 num, input t_u64 den);
        t_u64 quo;
        t_u64 rem;
        int   b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // arctan(2^-idx) in Q62 by its power series; entry zero holds pi in Q60
    function automatic t_u64 f_atan_q62(input int idx);
        t_u64 sum;
        t_u64 term;
        int   k;
        sum = '0;
        if (idx == 0) begin
            sum = PI_Q60;
        end else begin
            for (k = 0; idx * (2 * k + 1) <= 62; k++) begin
                term = f_udiv(t_u64'(1) << (62 - idx * (2 * k + 1)), t_u64'(2 * k + 1));
                if (k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    function automatic t_u64 f_to_frac(input t_u64 v, input int from, input int frac);
        int sh;
        sh = from - frac;
        return (v + (t_u64'(1) << (sh - 1))) >> sh;
    endfunction

    // inverse CORDIC gain
    function automatic t_u64 f_gain(input int stages, input int frac);
        t_u64 q;
        t_u64 root;
        t_u64 trial;
        int   i;
        int   b;
        q    = t_u64'(1) << 63;
        root = '0;
        for (i = 1; i < stages && i < TABLE_LEN; i++) begin
            q = q - f_udiv(q, (t_u64'(1) << (2 * i)) + t_u64'(1));
        end
        for (b = 31; b >= 0; b--) begin
            trial = root | (t_u64'(1) << b);
            if (trial * trial <= q) begin
                root = trial;
            end
        end
        if (frac < 32) begin
            return (root + (t_u64'(1) << (31 - frac))) >> (32 - frac);
        end
        return root << (frac - 32);
    endfunction

    // pi / 1.8e9 in Q93
    function automatic t_u64 f_deg_to_rad();
        t_u64 qh;
        t_u64 rm;
        qh = PI_Q60 / DEG_DIVISOR;
        rm = PI_Q60 % DEG_DIVISOR;
        return (qh << 24) + ((rm << 24) + DEG_DIVISOR / 2) / DEG_DIVISOR;
    endfunction

endpackage

>>> rtl/haversine_distance_top.sv
// ----------------------------------------------------------------------------
// Haversine great-circle distance
// Distance in centimetres between two points given in degrees times 10^7.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Word
// item     in   start / busy         i_first_latitude, i_first_longitude,
//                                    i_second_latitude, i_second_longitude
// result   out  o_valid (strobe)     o_distance_cm
// config   in   i_cfg_we             i_cfg_wdata (earth radius, metres)
//
// One word is taken every cycle; busy stays low.
// Each word passes through the sine/cosine cell row, the square-root cell row
// and the atan2 cell row, in that order.
// Reset clears the valid line and loads the radius with 6378137 m.
// Results leave on a one-cycle strobe and cannot be held off.
// ----------------------------------------------------------------------------
`include "haversine_distance_top_assert.svh"

module haversine_distance_top import hvd_pkg::*; #(
    parameter int CORDIC_STAGES = 24,
    parameter int FRACTION_BITS = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [22:0]        i_cfg_wdata,
    input  logic               start,
    input  logic signed [30:0] i_first_latitude,
    input  logic signed [31:0] i_first_longitude,
    input  logic signed [30:0] i_second_latitude,
    input  logic signed [31:0] i_second_longitude,
    output logic               busy,
    output logic               o_valid,
    output logic [30:0]        o_distance_cm
);

    localparam int N       = CORDIC_STAGES;
    localparam int F       = FRACTION_BITS;
    localparam int W       = F + 4;
    localparam int NW      = 2 * F + 2;
    localparam int RW      = F + 5;
    localparam int LATENCY = 2 * N + F + 17;
    localparam int SH_LAT  = 93 - F;
    localparam int SH_DIFF = 94 - F;
    localparam int PW_TRIG = 2 * W + 2 - F;
    localparam int PW_DIST = X100_W + 1 + W + 2 - F;

    localparam logic signed [W-1:0] PI_F      = W'(f_to_frac(PI_Q60, 60, F));
    localparam logic signed [W-1:0] HALF_PI_F = W'(f_to_frac(PI_Q60 >> 1, 60, F));
    localparam logic signed [W-1:0] GAIN_F    = W'(f_gain(N, F));
    localparam logic [F:0]          ONE_F     = {1'b1, {F{1'b0}}};
    localparam logic signed [W:0]   ONE_A     = (W + 1)'(ONE_F);
    localparam t_u64                D2R       = f_deg_to_rad();
    localparam logic [X100_W-1:0]   X100_RESET =
        X100_W'(RADIUS_RESET) * X100_W'(CM_PER_M);

    logic                 w_accept;
    logic [LATENCY-1:0]   r_vld;
    logic [X100_W-1:0]    r_radius_x100;

    // input capture
    logic signed [30:0] r_lat1, r_lat2;
    logic signed [31:0] r_lon1, r_lon2;
    // differences
    logic signed [30:0] r_l1, r_l2;
    logic signed [32:0] r_dlat, r_dlon;
    // lane magnitudes: first lat, second lat, half dlat, half dlon
    logic signed [33:0] w_val [0:3];
    logic [31:0]        r_mag [0:3];
    logic [3:0]         r_neg2;
    logic [63:0]        r_pph [0:3];
    logic [63:0]        r_ppl [0:3];
    logic [3:0]         r_neg3;
    logic signed [W-1:0] n_theta [0:3];
    logic signed [W-1:0] r_theta [0:3];
    logic signed [W-1:0] r_z0 [0:3];
    logic [3:0]          r_flip0;
    logic [3:0]          r_fl [0:N-1];

    logic signed [W-1:0] w_rx [0:N][0:3];
    logic signed [W-1:0] w_ry [0:N][0:3];
    logic signed [W-1:0] w_rz [0:N][0:3];

    logic signed [W-1:0] r_c1, r_c2, r_sl, r_sd;
    logic signed [PW_TRIG-1:0] w_sl2_full, w_sd2_full, w_p12_full, w_t_full;
    logic signed [W-1:0] r_sl2_d1, r_sl2_d2;
    logic signed [W:0]   w_a;
    logic [F:0]          n_a;
    logic [F:0]          r_v1, r_v2;

    logic [NW-1:0] w_rad  [0:F+1][0:1];
    logic [RW-1:0] w_rem  [0:F+1][0:1];
    logic [F:0]    w_root [0:F+1][0:1];

    logic signed [W-1:0] w_vx [0:N];
    logic signed [W-1:0] w_vy [0:N];
    logic signed [W-1:0] w_vz [0:N];

    logic signed [W-1:0]       w_ang2;
    logic signed [W-1:0]       r_ang;
    logic signed [PW_DIST-1:0] w_dist;
    logic [30:0]               r_dist;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_radius_x100 <= X100_RESET;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], w_accept};
            if (i_cfg_we) begin
                r_radius_x100 <= X100_W'(i_cfg_wdata) * X100_W'(CM_PER_M);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lat1 <= i_first_latitude;
        r_lon1 <= i_first_longitude;
        r_lat2 <= i_second_latitude;
        r_lon2 <= i_second_longitude;
        r_l1   <= r_lat1;
        r_l2   <= r_lat2;
        r_dlat <= 33'(r_lat2) - 33'(r_lat1);
        r_dlon <= 33'(r_lon2) - 33'(r_lon1);
    end

    // wrap longitude difference into one half-turn either way
    always_comb begin
        w_val[0] = 34'(r_l1);
        w_val[1] = 34'(r_l2);
        w_val[2] = 34'(r_dlat);
        w_val[3] = 34'(r_dlon);
        if (w_val[3] > LON_HALF) begin
            w_val[3] = w_val[3] - LON_TURN;
        end else if (w_val[3] < -LON_HALF) begin
            w_val[3] = w_val[3] + LON_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 4; l++) begin
            r_mag[l]  <= w_val[l][33] ? 32'(-w_val[l]) : 32'(w_val[l]);
            r_neg2[l] <= w_val[l][33];
            r_pph[l]  <= 64'(r_mag[l]) * 64'(D2R[63:32]);
            r_ppl[l]  <= 64'(r_mag[l]) * 64'(D2R[31:0]);
            r_neg3[l] <= r_neg2[l];
            r_theta[l] <= n_theta[l];
        end
    end

    // degrees to radians: recombine partial products, round, restore sign
    always_comb begin
        logic [96:0]  sum;
        logic [W-1:0] mag;
        int           sh;
        for (int l = 0; l < 4; l++) begin
            sh  = (l < 2) ? SH_LAT : SH_DIFF;
            sum = (97'(r_pph[l]) << 32) + 97'(r_ppl[l]) + (97'(1) << (sh - 1));
            mag = W'(sum >> sh);
            n_theta[l] = r_neg3[l] ? -signed'(mag) : signed'(mag);
        end
    end

    // fold into the CORDIC range, remembering to negate the results
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 4; l++) begin
            if (r_theta[l] > HALF_PI_F) begin
                r_z0[l]    <= r_theta[l] - PI_F;
                r_flip0[l] <= 1'b1;
            end else if (r_theta[l] < -HALF_PI_F) begin
                r_z0[l]    <= r_theta[l] + PI_F;
                r_flip0[l] <= 1'b1;
            end else begin
                r_z0[l]    <= r_theta[l];
                r_flip0[l] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fl[0] <= r_flip0;
        for (int k = 1; k < N; k++) begin
            r_fl[k] <= r_fl[k-1];
        end
    end

    genvar g, l;
    generate
        for (l = 0; l < 4; l++) begin : g_rot_in
            assign w_rx[0][l] = GAIN_F;
            assign w_ry[0][l] = '0;
            assign w_rz[0][l] = r_z0[l];
        end
        for (g = 0; g < N; g++) begin : g_rot_row
            for (l = 0; l < 4; l++) begin : g_rot_lane
                hvd_rot_cell #(.W(W), .FRAC(F), .IDX(g)) u_cell (
                    .i_clk (i_clk),
                    .i_x   (w_rx[g][l]),
                    .i_y   (w_ry[g][l]),
                    .i_z   (w_rz[g][l]),
                    .o_x   (w_rx[g+1][l]),
                    .o_y   (w_ry[g+1][l]),
                    .o_z   (w_rz[g+1][l])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_c1 <= r_fl[N-1][0] ? -w_rx[N][0] : w_rx[N][0];
        r_c2 <= r_fl[N-1][1] ? -w_rx[N][1] : w_rx[N][1];
        r_sl <= r_fl[N-1][2] ? -w_ry[N][2] : w_ry[N][2];
        r_sd <= r_fl[N-1][3] ? -w_ry[N][3] : w_ry[N][3];
    end

    hvd_smul #(.AW(W), .BW(W), .FRAC(F)) u_sl2 (
        .i_clk (i_clk), .i_a (r_sl), .i_b (r_sl), .o_p (w_sl2_full)
    );
    hvd_smul #(.AW(W), .BW(W), .FRAC(F)) u_sd2 (
        .i_clk (i_clk), .i_a (r_sd), .i_b (r_sd), .o_p (w_sd2_full)
    );
    hvd_smul #(.AW(W), .BW(W), .FRAC(F)) u_p12 (
        .i_clk (i_clk), .i_a (r_c1), .i_b (r_c2), .o_p (w_p12_full)
    );
    hvd_smul #(.AW(W), .BW(W), .FRAC(F)) u_term (
        .i_clk (i_clk),
        .i_a   (W'(w_p12_full)),
        .i_b   (W'(w_sd2_full)),
        .o_p   (w_t_full)
    );

    always_ff @(posedge i_clk) begin
        r_sl2_d1 <= W'(w_sl2_full);
        r_sl2_d2 <= r_sl2_d1;
    end

    // clamp the haversine term to [0, 1]
    always_comb begin
        w_a = (W + 1)'(r_sl2_d2) + (W + 1)'(W'(w_t_full));
        if (w_a[W]) begin
            n_a = '0;
        end else if (w_a > ONE_A) begin
            n_a = ONE_F;
        end else begin
            n_a = (F + 1)'(w_a);
        end
    end

    always_ff @(posedge i_clk) begin
        r_v1 <= ONE_F - n_a;
        r_v2 <= n_a;
    end

    assign w_rad[0][0]  = {1'b0, r_v1, {F{1'b0}}};
    assign w_rad[0][1]  = {1'b0, r_v2, {F{1'b0}}};
    assign w_rem[0][0]  = '0;
    assign w_rem[0][1]  = '0;
    assign w_root[0][0] = '0;
    assign w_root[0][1] = '0;

    generate
        for (g = 0; g <= F; g++) begin : g_sqrt_row
            for (l = 0; l < 2; l++) begin : g_sqrt_lane
                hvd_sqrt_cell #(.FRAC(F), .BIT(F - g)) u_cell (
                    .i_clk  (i_clk),
                    .i_rad  (w_rad[g][l]),
                    .i_rem  (w_rem[g][l]),
                    .i_root (w_root[g][l]),
                    .o_rad  (w_rad[g+1][l]),
                    .o_rem  (w_rem[g+1][l]),
                    .o_root (w_root[g+1][l])
                );
            end
        end
    endgenerate

    assign w_vx[0] = signed'(W'(w_root[F+1][0]));
    assign w_vy[0] = signed'(W'(w_root[F+1][1]));
    assign w_vz[0] = '0;

    generate
        for (g = 0; g < N; g++) begin : g_vec_row
            hvd_vec_cell #(.W(W), .FRAC(F), .IDX(g)) u_cell (
                .i_clk (i_clk),
                .i_x   (w_vx[g]),
                .i_y   (w_vy[g]),
                .i_z   (w_vz[g]),
                .o_x   (w_vx[g+1]),
                .o_y   (w_vy[g+1]),
                .o_z   (w_vz[g+1])
            );
        end
    endgenerate

    // central angle, dropping a negative rounding residue
    assign w_ang2 = w_vz[N] <<< 1;

    always_ff @(posedge i_clk) begin
        r_ang <= w_ang2[W-1] ? '0 : w_ang2;
    end

    hvd_smul #(.AW(X100_W + 1), .BW(W), .FRAC(F)) u_dist (
        .i_clk (i_clk),
        .i_a   (signed'({1'b0, r_radius_x100})),
        .i_b   (r_ang),
        .o_p   (w_dist)
    );

    always_ff @(posedge i_clk) begin
        if (w_dist[PW_DIST-1]) begin
            r_dist <= '0;
        end else if (w_dist > signed'(PW_DIST'(DIST_MAX))) begin
            r_dist <= DIST_MAX;
        end else begin
            r_dist <= 31'(w_dist);
        end
    end

    assign o_valid       = r_vld[LATENCY-1];
    assign o_distance_cm = r_dist;

    `HVD_ASSERT_DLY(a_word_delivered, i_clk, i_rst_n, w_accept, LATENCY, o_valid)
    `HVD_ASSERT_IMP(a_word_accounted, i_clk, i_rst_n, o_valid, $past(w_accept, LATENCY))
    `HVD_ASSERT_IMP(a_term_split, i_clk, i_rst_n, r_vld[N+11], ((F + 2)'(r_v1) + (F + 2)'(r_v2)) == (F + 2)'(ONE_F))

endmodule

>>> rtl/hvd_rot_cell.sv
// ----------------------------------------------------------------------------
// Rotation cell
// One micro-rotation of a sine/cosine CORDIC row.
// ----------------------------------------------------------------------------
module hvd_rot_cell import hvd_pkg::*; #(
    parameter int W    = 34,
    parameter int FRAC = 30,
    parameter int IDX  = 0
) (
    input  logic                i_clk,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic signed [W-1:0] i_z,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic signed [W-1:0] o_z
);

    localparam logic signed [W-1:0] ATAN = W'(f_to_frac(f_atan_q62(IDX), 62, FRAC));

    logic signed [W-1:0] r_x, r_y, r_z;
    logic signed [W-1:0] n_x, n_y, n_z;

    always_comb begin
        if (!i_z[W-1]) begin
            n_x = i_x - (i_y >>> IDX);
            n_y = i_y + (i_x >>> IDX);
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + (i_y >>> IDX);
            n_y = i_y - (i_x >>> IDX);
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

>>> rtl/hvd_vec_cell.sv
// ----------------------------------------------------------------------------
// Vectoring cell
// One micro-rotation of the atan2 CORDIC row.
// ----------------------------------------------------------------------------
module hvd_vec_cell import hvd_pkg::*; #(
    parameter int W    = 34,
    parameter int FRAC = 30,
    parameter int IDX  = 0
) (
    input  logic                i_clk,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic signed [W-1:0] i_z,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic signed [W-1:0] o_z
);

    localparam logic signed [W-1:0] ATAN = W'(f_to_frac(f_atan_q62(IDX), 62, FRAC));

    logic signed [W-1:0] r_x, r_y, r_z;
    logic signed [W-1:0] n_x, n_y, n_z;

    always_comb begin
        // drive y towards zero
        if (!i_y[W-1] && (i_y != '0)) begin
            n_x = i_x + (i_y >>> IDX);
            n_y = i_y - (i_x >>> IDX);
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - (i_y >>> IDX);
            n_y = i_y + (i_x >>> IDX);
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

>>> rtl/hvd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square-root cell
// One result bit of a restoring integer square root.
// ----------------------------------------------------------------------------
module hvd_sqrt_cell #(
    parameter int FRAC = 30,
    parameter int BIT  = 0,
    localparam int NW  = 2 * FRAC + 2,
    localparam int RW  = FRAC + 5
) (
    input  logic            i_clk,
    input  logic [NW-1:0]   i_rad,
    input  logic [RW-1:0]   i_rem,
    input  logic [FRAC:0]   i_root,
    output logic [NW-1:0]   o_rad,
    output logic [RW-1:0]   o_rem,
    output logic [FRAC:0]   o_root
);

    logic [NW-1:0] r_rad;
    logic [RW-1:0] r_rem, n_rem;
    logic [FRAC:0] r_root, n_root;
    logic [RW-1:0] w_shift;
    logic [RW-1:0] w_trial;

    always_comb begin
        w_shift = {i_rem[RW-3:0], i_rad[2*BIT+1 -: 2]};
        w_trial = RW'({i_root, 2'b01});
        if (w_shift >= w_trial) begin
            n_rem  = w_shift - w_trial;
            n_root = {i_root[FRAC-1:0], 1'b1};
        end else begin
            n_rem  = w_shift;
            n_root = {i_root[FRAC-1:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= i_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

>>> rtl/hvd_smul.sv
// ----------------------------------------------------------------------------
// Rounding fixed-point multiplier
// Signed product scaled down by 2^FRAC, magnitude rounded half away from zero.
// ----------------------------------------------------------------------------
module hvd_smul #(
    parameter int AW   = 32,
    parameter int BW   = 32,
    parameter int FRAC = 30,
    localparam int PW  = AW + BW + 2 - FRAC
) (
    input  logic                 i_clk,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [PW-1:0] o_p
);

    localparam logic [AW+BW:0] HALF = (AW + BW + 1)'(1) << (FRAC - 1);

    logic [AW-1:0]          w_am;
    logic [BW-1:0]          w_bm;
    logic [AW+BW-1:0]       r_prod;
    logic                   r_neg;
    logic [AW+BW:0]         w_sum;
    logic [PW-2:0]          w_mag;
    logic signed [PW-1:0]   w_ext;
    logic signed [PW-1:0]   r_p, n_p;

    assign w_am = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
    assign w_bm = i_b[BW-1] ? BW'(-i_b) : BW'(i_b);

    always_ff @(posedge i_clk) begin
        r_prod <= (AW + BW)'(w_am) * (AW + BW)'(w_bm);
        r_neg  <= i_a[AW-1] ^ i_b[BW-1];
    end

    always_comb begin
        w_sum = {1'b0, r_prod} + HALF;
        w_mag = (PW - 1)'(w_sum >> FRAC);
        w_ext = signed'({1'b0, w_mag});
        n_p   = r_neg ? -w_ext : w_ext;
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule
